### design/ihs_pkg.sv
// ---------------------------------------------------------------------------
// ihs_pkg: shared types and constants of the image header sniffer
// Format and status codes, magic byte values, header layout and the
// per-format magic byte checks.
// ---------------------------------------------------------------------------
package ihs_pkg;

  // header length and byte counter width
  localparam int unsigned HeaderBytes = 26;
  localparam int unsigned IdxW        = $clog2(HeaderBytes + 1);

  // format codes
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_JPEG = 3'd1;
  localparam logic [2:0] FMT_GIF  = 3'd2;
  localparam logic [2:0] FMT_PNG  = 3'd3;
  localparam logic [2:0] FMT_BMP  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL = 3'd1;
  localparam logic [2:0] ST_UNSUPP    = 3'd2;
  localparam logic [2:0] ST_BAD_DIM   = 3'd3;
  localparam logic [2:0] ST_JPEG      = 3'd4;

  // match flag bit positions
  localparam int unsigned FlagJpeg = 0;
  localparam int unsigned FlagGif  = 1;
  localparam int unsigned FlagPng  = 2;
  localparam int unsigned FlagBmp  = 3;

  // magic byte values
  localparam logic [7:0] B_FF = 8'hFF;
  localparam logic [7:0] B_D8 = 8'hD8;
  localparam logic [7:0] B_E0 = 8'hE0;
  localparam logic [7:0] B_89 = 8'h89;
  localparam logic [7:0] B_0D = 8'h0D;
  localparam logic [7:0] B_0A = 8'h0A;
  localparam logic [7:0] B_1A = 8'h1A;
  localparam logic [7:0] CH_J = 8'h4A;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_M = 8'h4D;

  // parser view of one file after the latest word
  typedef struct packed {
    logic        done;
    logic [3:0]  flags;
    logic [31:0] width;
    logic [31:0] height;
  } hdr_state_t;

  // jpeg / jfif magic
  function automatic logic jpeg_ok(input logic [IdxW-1:0] i, input logic [7:0] b);
    logic r;
    unique case (i)
      IdxW'(0): r = (b == B_FF);
      IdxW'(1): r = (b == B_D8);
      IdxW'(2): r = (b == B_FF);
      IdxW'(3): r = (b == B_E0);
      IdxW'(6): r = (b == CH_J);
      IdxW'(7): r = (b == CH_F);
      IdxW'(8): r = (b == CH_I);
      IdxW'(9): r = (b == CH_F);
      default:  r = 1'b1;
    endcase
    return r;
  endfunction

  // gif magic
  function automatic logic gif_ok(input logic [IdxW-1:0] i, input logic [7:0] b);
    logic r;
    unique case (i)
      IdxW'(0): r = (b == CH_G);
      IdxW'(1): r = (b == CH_I);
      IdxW'(2): r = (b == CH_F);
      default:  r = 1'b1;
    endcase
    return r;
  endfunction

  // png signature and ihdr chunk tag
  function automatic logic png_ok(input logic [IdxW-1:0] i, input logic [7:0] b);
    logic r;
    unique case (i)
      IdxW'(0):  r = (b == B_89);
      IdxW'(1):  r = (b == CH_P);
      IdxW'(2):  r = (b == CH_N);
      IdxW'(3):  r = (b == CH_G);
      IdxW'(4):  r = (b == B_0D);
      IdxW'(5):  r = (b == B_0A);
      IdxW'(6):  r = (b == B_1A);
      IdxW'(7):  r = (b == B_0A);
      IdxW'(12): r = (b == CH_I);
      IdxW'(13): r = (b == CH_H);
      IdxW'(14): r = (b == CH_D);
      IdxW'(15): r = (b == CH_R);
      default:   r = 1'b1;
    endcase
    return r;
  endfunction

  // bmp magic
  function automatic logic bmp_ok(input logic [IdxW-1:0] i, input logic [7:0] b);
    logic r;
    unique case (i)
      IdxW'(0): r = (b == CH_B);
      IdxW'(1): r = (b == CH_M);
      default:  r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

### design/ihs_header_parser.sv
// ---------------------------------------------------------------------------
// ihs_header_parser: per-file header state
// Narrows the candidate formats byte by byte and gathers width and height
// from the header; returns to its reset state after the last word of a file.
// ---------------------------------------------------------------------------
module ihs_header_parser import ihs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] file_byte_i,
  input  logic       end_of_file_i,
  output hdr_state_t post_o
);

  logic [IdxW-1:0] idx_q, idx_d, idx_upd;
  hdr_state_t      st_q, st_d, st_upd;
  logic [1:0]      lane;
  logic [3:0]      ok_vec;

  // header update for the current word
  always_comb begin
    st_upd  = st_q;
    idx_upd = idx_q;
    ok_vec  = {bmp_ok(idx_q, file_byte_i), png_ok(idx_q, file_byte_i),
               gif_ok(idx_q, file_byte_i), jpeg_ok(idx_q, file_byte_i)};
    lane    = 2'b00;
    if (!st_q.done) begin
      st_upd.flags = st_q.flags & ok_vec;
      // dimension capture, gif first, then png, then bmp
      if (st_upd.flags[FlagGif]) begin
        if (idx_q == IdxW'(6)) begin
          st_upd.width[7:0] = st_q.width[7:0] | file_byte_i;
        end else if (idx_q == IdxW'(7)) begin
          st_upd.width[15:8] = st_q.width[15:8] | file_byte_i;
        end else if (idx_q == IdxW'(8)) begin
          st_upd.height[7:0] = st_q.height[7:0] | file_byte_i;
        end else if (idx_q == IdxW'(9)) begin
          st_upd.height[15:8] = st_q.height[15:8] | file_byte_i;
        end
      end else if (st_upd.flags[FlagPng]) begin
        if (idx_q >= IdxW'(16) && idx_q <= IdxW'(19)) begin
          st_upd.width = {st_q.width[23:0], file_byte_i};
        end else if (idx_q >= IdxW'(20) && idx_q <= IdxW'(23)) begin
          st_upd.height = {st_q.height[23:0], file_byte_i};
        end
      end else if (st_upd.flags[FlagBmp]) begin
        if (idx_q >= IdxW'(18) && idx_q <= IdxW'(21)) begin
          lane = 2'(idx_q - IdxW'(18));
          st_upd.width[8*lane +: 8] = st_q.width[8*lane +: 8] | file_byte_i;
        end else if (idx_q >= IdxW'(22) && idx_q <= IdxW'(25)) begin
          lane = 2'(idx_q - IdxW'(22));
          st_upd.height[8*lane +: 8] = st_q.height[8*lane +: 8] | file_byte_i;
        end
      end
      // byte counter saturates at the header length
      idx_upd = IdxW'(idx_q + 1'b1);
      if (idx_upd >= IdxW'(HeaderBytes)) begin
        idx_upd     = IdxW'(HeaderBytes);
        st_upd.done = 1'b1;
      end
    end
  end

  assign post_o = st_upd;

  // restart after the last word of a file
  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    if (accept_i) begin
      if (end_of_file_i) begin
        st_d  = '{done: 1'b0, flags: 4'hF, width: '0, height: '0};
        idx_d = '0;
      end else begin
        st_d  = st_upd;
        idx_d = idx_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{done: 1'b0, flags: 4'hF, width: '0, height: '0};
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
    end
  end

endmodule

### design/ihs_result_reg.sv
// ---------------------------------------------------------------------------
// ihs_result_reg: classification and result register
// Turns the final header state of a file into format and status and holds
// the result word until the consumer takes it.
// ---------------------------------------------------------------------------
module ihs_result_reg import ihs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  hdr_state_t  post_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  format_code_o,
  output logic [2:0]  status_o,
  output logic [30:0] width_o,
  output logic [30:0] height_o
);

  logic        valid_q, valid_d;
  logic [2:0]  fmt_q, fmt_d, st_q, st_d;
  logic [30:0] w_q, w_d, h_q, h_d;
  logic        dim_bad;

  // classify the file
  always_comb begin
    fmt_d   = FMT_NONE;
    st_d    = ST_OK;
    w_d     = '0;
    h_d     = '0;
    dim_bad = (post_i.width == '0) || post_i.width[31] ||
              (post_i.height == '0) || post_i.height[31];
    priority if (!post_i.done) begin
      st_d = ST_TOO_SMALL;
    end else if (post_i.flags[FlagJpeg]) begin
      fmt_d = FMT_JPEG;
      st_d  = ST_JPEG;
    end else if (post_i.flags[FlagGif] || post_i.flags[FlagPng] ||
                 post_i.flags[FlagBmp]) begin
      if (post_i.flags[FlagGif]) begin
        fmt_d = FMT_GIF;
      end else if (post_i.flags[FlagPng]) begin
        fmt_d = FMT_PNG;
      end else begin
        fmt_d = FMT_BMP;
      end
      if (dim_bad) begin
        st_d = ST_BAD_DIM;
      end else begin
        w_d = post_i.width[30:0];
        h_d = post_i.height[30:0];
      end
    end else begin
      st_d = ST_UNSUPP;
    end
  end

  // output valid
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fmt_q <= fmt_d;
      st_q  <= st_d;
      w_q   <= w_d;
      h_q   <= h_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign format_code_o = fmt_q;
  assign status_o      = st_q;
  assign width_o       = w_q;
  assign height_o      = h_q;

endmodule

### design/image_header_sniffer_top.sv
// A result appears in the cycle after the word carrying end_of_file is taken.
// Throughput: one byte per cycle while the result register does not stall the input.
// Input is taken whenever the result register is empty or being drained.
// Reset: asynchronous, active low; clears the header state (all formats
// possible) and empties the result register.
// ---------------------------------------------------------------------------
// image_header_sniffer_top: image file format and size detector
// Streams file bytes, matches jpeg/gif/png/bmp magic in the header and
// reports format, status and dimensions once per file.
// ---------------------------------------------------------------------------
module image_header_sniffer_top import ihs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  format_code_o,
  output logic [2:0]  status_o,
  output logic [30:0] width_o,
  output logic [30:0] height_o
);

  logic       accept;
  hdr_state_t post;

  // input handshake
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ihs_header_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .file_byte_i   (file_byte_i),
    .end_of_file_i (end_of_file_i),
    .post_o        (post)
  );

  ihs_result_reg u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && end_of_file_i),
    .post_i        (post),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .format_code_o (format_code_o),
    .status_o      (status_o),
    .width_o       (width_o),
    .height_o      (height_o)
  );

  // last word of a file always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_file_i) |=> out_valid_o)
    else $error("result missing after end of file");

  // short or unmatched files carry no format
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_TOO_SMALL || status_o == ST_UNSUPP))
      |-> (format_code_o == FMT_NONE))
    else $error("format reported on failed file");

  // dimensions only on a good result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (width_o == '0 && height_o == '0))
    else $error("dimensions on non-ok result");

  // ok results carry nonzero dimensions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> (width_o != '0 && height_o != '0))
    else $error("zero dimension on ok result");

endmodule
